>>> hw/rtl/three_wire_rtc_serial_master_unit_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_UNIT_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_UNIT_MACROS_SVH

// A property that must hold at every sampled edge out of reset.
`define TWRTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An antecedent that must be followed in the same cycle by a consequent.
`define TWRTC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/twrtc_pkg.sv
package twrtc_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BCNT_W        = 4;

  localparam logic [BYTE_W-1:0] CTRL_ADDR_RESET = 8'h8E;
  localparam logic [BYTE_W-1:0] WP_CLEAR        = 8'h00;
  localparam logic [BYTE_W-1:0] WP_SET          = 8'h80;
  localparam logic [BYTE_W-1:0] READ_FLAG       = 8'h01;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_READ      = 2'd2,
    CMD_PROT_WRITE = 2'd3
  } cmd_e;

  // Stage of a protected write; SUB_NONE for a plain command.
  typedef enum logic [1:0] {
    SUB_NONE   = 2'd0,
    SUB_UNLOCK = 2'd1,
    SUB_MAIN   = 2'd2,
    SUB_LOCK   = 2'd3
  } sub_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_END  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic              data_pin_in;
  } item_t;

  typedef struct packed {
    logic              enable_pin;
    logic              clock_pin;
    logic              data_pin_out;
    logic              data_drive;
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
    logic              busy_res;
  } result_t;

  function automatic logic [BYTE_W-1:0] stage_address(input sub_e sub, input logic rd,
                                                      input logic [BYTE_W-1:0] addr,
                                                      input logic [BYTE_W-1:0] ctrl);
    logic [BYTE_W-1:0] a;
    if (sub == SUB_UNLOCK || sub == SUB_LOCK) begin
      a = ctrl;
    end else if (rd) begin
      a = addr | READ_FLAG;
    end else begin
      a = addr;
    end
    return a;
  endfunction

  function automatic logic [BYTE_W-1:0] stage_data(input sub_e sub,
                                                   input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] d;
    case (sub)
      SUB_UNLOCK: d = WP_CLEAR;
      SUB_LOCK:   d = WP_SET;
      default:    d = data;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/twrtc_in_if.sv
interface twrtc_in_if import twrtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [BYTE_W-1:0] address;
  logic [BYTE_W-1:0] write_data;
  logic              data_pin_in;

  modport source (output valid, command, address, write_data, data_pin_in, input ready);
  modport sink   (input valid, command, address, write_data, data_pin_in, output ready);
endinterface

>>> hw/rtl/twrtc_out_if.sv
interface twrtc_out_if import twrtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              enable_pin;
  logic              clock_pin;
  logic              data_pin_out;
  logic              data_drive;
  logic [BYTE_W-1:0] read_byte;
  logic              done_res;
  logic              busy_res;

  modport source (output valid, enable_pin, clock_pin, data_pin_out, data_drive, read_byte,
                  done_res, busy_res, input ready);
  modport sink   (input valid, enable_pin, clock_pin, data_pin_out, data_drive, read_byte,
                  done_res, busy_res, output ready);
endinterface

>>> hw/rtl/twrtc_cfg_if.sv
interface twrtc_cfg_if import twrtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/three_wire_rtc_serial_master_unit.sv
// Channel  | Dir | Payload                                            | Handshake
// ---------+-----+----------------------------------------------------+------------
// in_i     | in  | command, address, write_data, data_pin_in          | valid/ready
// out_o    | out | enable_pin, clock_pin, data_pin_out, data_drive,   | valid/ready
//          |     | read_byte, done_res, busy_res                      |
// cfg_i    | in  | control address byte                               | valid/ready
//
// Every accepted item is one half-bit tick and produces exactly one result item.
// An item is accepted in any cycle in which the result register is empty or is being
// taken, so the block sustains one item per cycle; the result is registered and appears in the cycle after.
// The rate is set by the single state update of the link sequencer per item.
// A stall on the result side holds the result register and, with it, the input side.
// Reset clears the sequencer to idle and the control address to its default.
module three_wire_rtc_serial_master_unit import twrtc_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  twrtc_in_if.sink    in_i,
  twrtc_out_if.source out_o,
  twrtc_cfg_if.sink   cfg_i
);

  logic [BYTE_W-1:0] ctrl_addr_q;
  logic              out_valid_q;
  result_t           res_q;
  result_t           res;
  item_t             item;
  logic              in_fire;

  // The configuration register is always writable; the user must write only while idle (not enforced).
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_addr_q <= CTRL_ADDR_RESET;
    end else if (cfg_i.valid) begin
      ctrl_addr_q <= cfg_i.data;
    end
  end

  // The input side proceeds whenever the result register can take a new value.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign item.command     = in_i.command;
  assign item.address     = in_i.address;
  assign item.write_data  = in_i.write_data;
  assign item.data_pin_in = in_i.data_pin_in;

  // Sequencer: pin levels and next state for one tick, all in one pass.
  twrtc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .item_i      (item),
    .ctrl_addr_i (ctrl_addr_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.enable_pin   = res_q.enable_pin;
  assign out_o.clock_pin    = res_q.clock_pin;
  assign out_o.data_pin_out = res_q.data_pin_out;
  assign out_o.data_drive   = res_q.data_drive;
  assign out_o.read_byte    = res_q.read_byte;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.busy_res     = res_q.busy_res;

endmodule

>>> hw/rtl/twrtc_engine.sv
module twrtc_engine import twrtc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  logic [BYTE_W-1:0] ctrl_addr_i,
  output result_t           result_o
);

  phase_e            phase_q, phase_d, cur_phase;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d, bcnt, bcnt_inc;
  logic [BYTE_W-1:0] shift_q, shift_d, shift;
  logic [BYTE_W-1:0] addr_q, addr_d, addr;
  logic [BYTE_W-1:0] data_q, data_d, data;
  logic              rd_q, rd_d, rd;
  sub_e              sub_q, sub_d, sub, sub_inc;
  logic [BYTE_W-1:0] last_q, last_d;
  logic              is_idle, start, reading;

  always_comb begin
    is_idle  = (phase_q != PH_LOW) && (phase_q != PH_HIGH) && (phase_q != PH_END);
    start    = is_idle && (item_i.command != CMD_TICK);
    rd       = start ? (item_i.command == CMD_READ) : rd_q;
    sub      = start ? ((item_i.command == CMD_PROT_WRITE) ? SUB_UNLOCK : SUB_NONE) : sub_q;
    addr     = start ? item_i.address : addr_q;
    data     = start ? item_i.write_data : data_q;
    shift    = start ? stage_address(sub, rd, addr, ctrl_addr_i) : shift_q;
    bcnt     = start ? '0 : bcnt_q;
    cur_phase = start ? PH_LOW : (is_idle ? PH_IDLE : phase_q);
    reading  = rd && bcnt[BCNT_W-1];
    bcnt_inc = bcnt + BCNT_W'(1);
    sub_inc  = sub_e'(sub + 2'd1);

    phase_d = cur_phase;
    bcnt_d  = bcnt;
    shift_d = shift;
    addr_d  = addr;
    data_d  = data;
    rd_d    = rd;
    sub_d   = sub;
    last_d  = last_q;

    result_o.enable_pin   = 1'b0;
    result_o.clock_pin    = 1'b0;
    result_o.data_pin_out = 1'b0;
    result_o.data_drive   = 1'b1;
    result_o.done_res     = 1'b0;

    unique case (cur_phase)
      PH_LOW: begin
        result_o.enable_pin   = 1'b1;
        result_o.data_drive   = !reading;
        result_o.data_pin_out = reading ? 1'b0 : shift[0];
        phase_d = PH_HIGH;
      end
      PH_HIGH: begin
        result_o.enable_pin   = 1'b1;
        result_o.clock_pin    = 1'b1;
        result_o.data_drive   = !reading;
        result_o.data_pin_out = reading ? 1'b0 : shift[0];
        if (reading) begin
          shift_d = {item_i.data_pin_in, shift[BYTE_W-1:1]};
        end else begin
          shift_d = {1'b0, shift[BYTE_W-1:1]};
        end
        bcnt_d = bcnt_inc;
        if (bcnt_inc == BCNT_W'(BITS_PER_BYTE)) begin
          // Address byte is out: load the data byte, or clear for a read.
          shift_d = rd ? '0 : stage_data(sub, data);
          phase_d = PH_LOW;
        end else if (bcnt_inc == '0) begin
          phase_d = PH_END;
        end else begin
          phase_d = PH_LOW;
        end
      end
      PH_END: begin
        result_o.clock_pin = 1'b1;
        if (rd) begin
          last_d = shift;
        end
        if (sub == SUB_UNLOCK || sub == SUB_MAIN) begin
          sub_d   = sub_inc;
          phase_d = PH_LOW;
          bcnt_d  = '0;
          shift_d = stage_address(sub_inc, rd, addr, ctrl_addr_i);
        end else begin
          sub_d   = SUB_NONE;
          phase_d = PH_IDLE;
          bcnt_d  = '0;
          result_o.done_res = 1'b1;
        end
      end
      default: begin
      end
    endcase

    result_o.read_byte = last_d;
    result_o.busy_res  = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bcnt_q  <= '0;
      shift_q <= '0;
      addr_q  <= '0;
      data_q  <= '0;
      rd_q    <= 1'b0;
      sub_q   <= SUB_NONE;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
      rd_q    <= rd_d;
      sub_q   <= sub_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> hw/rtl/twrtc_checker.sv
`include "three_wire_rtc_serial_master_unit_macros.svh"

module twrtc_checker import twrtc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic enable_pin,
  input logic clock_pin,
  input logic data_pin_out,
  input logic data_drive,
  input logic done_res,
  input logic busy_res
);

  // A waiting result blocks the input side.
  `TWRTC_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while result stalled")

  // The end of a command is the end tick: enable low, clock high, nothing pending.
  `TWRTC_ASSERT_IMPL(a_done_end_tick, out_valid && done_res, !busy_res && !enable_pin && clock_pin, "done outside an end tick")

  // The data pin is released only inside a transaction and then reads as zero.
  `TWRTC_ASSERT_IMPL(a_release_in_frame, out_valid && !data_drive, enable_pin && !data_pin_out, "pin released outside a transaction")

  // An idle tick drives the pin low.
  `TWRTC_ASSERT_IMPL(a_idle_levels, out_valid && !enable_pin && !clock_pin, data_drive && !data_pin_out && !busy_res, "bad idle pin levels")

endmodule

bind three_wire_rtc_serial_master_unit twrtc_checker u_twrtc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .enable_pin   (out_o.enable_pin),
  .clock_pin    (out_o.clock_pin),
  .data_pin_out (out_o.data_pin_out),
  .data_drive   (out_o.data_drive),
  .done_res     (out_o.done_res),
  .busy_res     (out_o.busy_res)
);
